FILE: hdl/taqnt_pkg.sv
`default_nettype none

package taqnt_pkg;

  // default matrix size limit, in elements
  localparam int unsigned MaxElements = 32'd16777216;

  // byte address of the format register
  localparam logic [1:0] AddrFormat = 2'd0;

  // element format codes; any other code is handled as float32
  localparam logic [1:0] FmtBf16 = 2'd1;
  localparam logic [1:0] FmtHalf = 2'd2;

  // float32 bit pattern of 1e-10
  localparam logic [31:0] ScaleMin = 32'h2EDB_E6FF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SUM,
    S_DINIT,
    S_DIV,
    S_NORM,
    S_LATCH,
    S_QOUT
  } state_e;

  typedef struct packed {
    logic load;   // capture input word
    logic align;  // accumulate: align operands
    logic sum;    // accumulate: add, round, count
    logic dinit;  // scale: load divider
    logic dstep;  // scale: one quotient bit
    logic nstep;  // scale: one normalising shift
    logic latch;  // scale: round and store
    logic qcmp;   // quantise: threshold compare
    logic qout;   // quantise: narrow and load output
  } cmd_t;

  typedef struct packed {
    logic op;
    logic last;
    logic cnt_full;
    logic sum_special;
    logic div_last;
    logic norm_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/taqnt_ctrl.sv
`default_nettype none

module taqnt_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  taqnt_pkg::status_t sts_i,
  output taqnt_pkg::cmd_t    cmd_o
);

  taqnt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= taqnt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      taqnt_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = taqnt_pkg::S_EXEC;
        end
      end
      taqnt_pkg::S_EXEC: begin
        // both units write disjoint registers; only the relevant one matters
        cmd_o.align = 1'b1;
        cmd_o.qcmp  = 1'b1;
        if (sts_i.op) begin
          state_d = taqnt_pkg::S_QOUT;
        end else if (!sts_i.cnt_full) begin
          state_d = taqnt_pkg::S_SUM;
        end else if (sts_i.last) begin
          state_d = taqnt_pkg::S_DINIT;
        end else begin
          state_d = taqnt_pkg::S_IDLE;
        end
      end
      taqnt_pkg::S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = sts_i.last ? taqnt_pkg::S_DINIT : taqnt_pkg::S_IDLE;
      end
      taqnt_pkg::S_DINIT: begin
        cmd_o.dinit = 1'b1;
        state_d     = sts_i.sum_special ? taqnt_pkg::S_LATCH : taqnt_pkg::S_DIV;
      end
      taqnt_pkg::S_DIV: begin
        cmd_o.dstep = 1'b1;
        if (sts_i.div_last) begin
          state_d = taqnt_pkg::S_NORM;
        end
      end
      taqnt_pkg::S_NORM: begin
        if (sts_i.norm_done) begin
          state_d = taqnt_pkg::S_LATCH;
        end else begin
          cmd_o.nstep = 1'b1;
        end
      end
      taqnt_pkg::S_LATCH: begin
        cmd_o.latch = 1'b1;
        state_d     = taqnt_pkg::S_IDLE;
      end
      taqnt_pkg::S_QOUT: begin
        if (sts_i.out_free) begin
          cmd_o.qout = 1'b1;
          state_d    = taqnt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = taqnt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/taqnt_dp.sv
`default_nettype none

module taqnt_dp #(
  parameter int unsigned MAX_ELEMENTS = taqnt_pkg::MaxElements
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  taqnt_pkg::cmd_t     cmd_i,
  output taqnt_pkg::status_t  sts_o,
  input  wire  [1:0]          fmt_i,
  input  wire                 opcode_i,
  input  wire  [31:0]         value_bits_i,
  input  wire                 is_last_i,
  input  wire                 out_stall_i,
  output logic                out_valid_o,
  output logic [31:0]         quantized_bits_o,
  output logic                last_of_matrix_o,
  output logic                passed_through_o
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);  // element counter
  localparam int QW = 48 + CW;                    // quotient register
  localparam int SW = $clog2(QW);                 // divider step counter
  localparam int NW = $clog2(CW + 2);             // normalise shift counter

  // ---------------------------------------------------------------- formats
  function automatic logic [31:0] h2s(input logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] p;
    logic [3:0] n;
    logic [10:0] mn;
    logic [7:0] e;
    ex  = h[14:10];
    man = h[9:0];
    p   = '0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = 4'(i);
    end
    n  = 4'd10 - p;
    mn = {1'b0, man} << n;
    e  = 8'd113 - {4'd0, n};
    if (ex == 5'd0) begin
      h2s = (man == '0) ? {h[15], 31'd0} : {h[15], e, mn[9:0], 13'd0};
    end else if (ex == 5'h1f) begin
      h2s = {h[15], 8'hff, man, 13'd0};
    end else begin
      h2s = {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
    end
  endfunction

  function automatic logic [15:0] s2h(input logic [31:0] x);
    logic [7:0] ex;
    logic [22:0] man;
    logic signed [9:0] e;
    logic [9:0] shift;
    logic [23:0] m;
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] half;
    logic [14:0] h;
    logic [12:0] r13;
    ex    = x[30:23];
    man   = x[22:0];
    e     = $signed({2'd0, ex}) - 10'sd112;
    shift = 10'd14 - 10'(e);
    m     = {1'b1, man};
    q     = m >> shift[4:0];
    rem   = m & ~(24'hff_ffff << shift[4:0]);
    half  = 24'd1 << (shift[4:0] - 5'd1);
    h     = {e[4:0], man[22:13]};
    r13   = man[12:0];
    if (ex == 8'hff) begin
      s2h = {x[31], 5'h1f, (man != '0) ? (10'h200 | man[22:13]) : 10'd0};
    end else if (e >= 10'sd31) begin
      s2h = {x[31], 5'h1f, 10'd0};
    end else if (e <= 10'sd0) begin
      if (ex == 8'd0 || shift > 10'd24) begin
        s2h = {x[31], 15'd0};
      end else begin
        if (rem > half || (rem == half && q[0])) q = q + 24'd1;
        s2h = {x[31], q[14:0]};
      end
    end else begin
      if (r13 > 13'h1000 || (r13 == 13'h1000 && h[0])) h = h + 15'd1;
      s2h = {x[31], h};
    end
  endfunction

  function automatic logic [15:0] s2bf(input logic [31:0] x);
    logic [31:0] t;
    t = x + 32'h0000_7fff + {31'd0, x[16]};
    if (x[30:0] > 31'h7f80_0000) begin
      s2bf = x[31:16] | 16'h0040;
    end else begin
      s2bf = t[31:16];
    end
  endfunction

  // ------------------------------------------------------------ input word
  logic        op_q;
  logic [31:0] raw_q;
  logic        last_q;
  logic [31:0] w32;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      raw_q  <= value_bits_i;
      last_q <= is_last_i;
    end
  end

  always_comb begin
    case (fmt_i)
      taqnt_pkg::FmtBf16: w32 = {raw_q[15:0], 16'd0};
      taqnt_pkg::FmtHalf: w32 = h2s(raw_q[15:0]);
      default:            w32 = raw_q;
    endcase
  end

  // ---------------------------------------------------------- accumulator
  logic [31:0]   abs_sum_q;
  logic [CW-1:0] count_q;

  logic        al_spec_q;
  logic [31:0] al_spec_val_q;
  logic [7:0]  al_e_q;
  logic [23:0] al_ml_q;
  logic [49:0] al_ms_q;
  logic        al_st_q;

  logic [31:0] b_abs;
  logic        a_nan, b_nan, a_inf, b_inf;
  logic [7:0]  ea, eb, el, es, dexp;
  logic [23:0] ma, mb, ml, msm;
  logic [49:0] wide, shifted;
  logic        st;

  always_comb begin
    b_abs = {1'b0, w32[30:0]};
    a_nan = (abs_sum_q[30:23] == 8'hff) && (abs_sum_q[22:0] != '0);
    b_nan = (b_abs[30:23] == 8'hff) && (b_abs[22:0] != '0);
    a_inf = (abs_sum_q[30:23] == 8'hff) && (abs_sum_q[22:0] == '0);
    b_inf = (b_abs[30:23] == 8'hff) && (b_abs[22:0] == '0);
    ea    = (abs_sum_q[30:23] == 8'd0) ? 8'd1 : abs_sum_q[30:23];
    eb    = (b_abs[30:23] == 8'd0) ? 8'd1 : b_abs[30:23];
    ma    = {abs_sum_q[30:23] != 8'd0, abs_sum_q[22:0]};
    mb    = {b_abs[30:23] != 8'd0, b_abs[22:0]};
    if (eb > ea) begin
      el = eb; ml = mb; es = ea; msm = ma;
    end else begin
      el = ea; ml = ma; es = eb; msm = mb;
    end
    dexp = el - es;
    wide = {msm, 26'd0};
    if (dexp > 8'd49) begin
      shifted = '0;
      st      = |msm;
    end else begin
      shifted = wide >> dexp[5:0];
      st      = |(wide & ~({50{1'b1}} << dexp[5:0]));
    end
  end

  // add, normalise by one place at most (operands share a sign), round
  logic [50:0] sumw;
  logic [23:0] sm;
  logic        sg, sst, srnd;
  logic [8:0]  sef;
  logic [30:0] spk;
  logic [31:0] sum_res;

  always_comb begin
    sumw = {1'b0, al_ml_q, 26'd0} + {1'b0, al_ms_q};
    if (sumw[50]) begin
      sm  = sumw[50:27];
      sg  = sumw[26];
      sst = (|sumw[25:0]) | al_st_q;
      sef = {1'b0, al_e_q} + 9'd1;
    end else begin
      sm  = sumw[49:26];
      sg  = sumw[25];
      sst = (|sumw[24:0]) | al_st_q;
      sef = sumw[49] ? {1'b0, al_e_q} : 9'd0;
    end
    srnd = sg & (sst | sm[0]);
    spk  = {sef[7:0], sm[22:0]} + {30'd0, srnd};
    if (al_spec_q) begin
      sum_res = al_spec_val_q;
    end else if (sef >= 9'd255) begin
      sum_res = 32'h7f80_0000;
    end else begin
      sum_res = {1'b0, spk};
    end
  end

  // ------------------------------------------------------- scale divider
  logic [QW-1:0] nq_q;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] dvs_q;
  logic [SW-1:0] step_q;
  logic [NW-1:0] nsh_q;
  logic [31:0]   scale_q;
  logic          skip_q;

  logic [CW:0]   dtmp;
  logic          dge;
  logic [23:0]   lm;
  logic          lg, lst, lrnd;
  logic [9:0]    lexp;
  logic [30:0]   lpk;
  logic [31:0]   lscale;

  always_comb begin
    dtmp = {rem_q, nq_q[QW-1]};
    dge  = dtmp >= {1'b0, dvs_q};
    lm   = nq_q[QW-1 -: 24];
    lg   = nq_q[QW-25];
    lst  = (|nq_q[QW-26:0]) | (rem_q != '0);
    lrnd = lg & (lst | lm[0]);
    lexp = {2'd0, abs_sum_q[30:23]} - 10'(nsh_q);
    lpk  = {lexp[7:0], lm[22:0]} + {30'd0, lrnd};
    if (abs_sum_q[30:23] == 8'hff) begin
      lscale = abs_sum_q;
    end else if (abs_sum_q[30:23] == 8'd0 || lexp[9] || lexp == 10'd0) begin
      lscale = '0;  // far below threshold: value never used
    end else begin
      lscale = {1'b0, lpk};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_sum_q <= '0;
      count_q   <= '0;
      scale_q   <= '0;
      skip_q    <= 1'b0;
    end else begin
      if (cmd_i.sum) begin
        abs_sum_q <= sum_res;
        count_q   <= count_q + CW'(1);
      end
      if (cmd_i.latch) begin
        scale_q   <= lscale;
        skip_q    <= lscale < taqnt_pkg::ScaleMin;
        abs_sum_q <= '0;
        count_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.align) begin
      al_spec_q     <= a_nan | b_nan | a_inf | b_inf;
      al_spec_val_q <= a_nan ? (abs_sum_q | 32'h0040_0000) :
                       b_nan ? (b_abs | 32'h0040_0000) : 32'h7f80_0000;
      al_e_q        <= el;
      al_ml_q       <= ml;
      al_ms_q       <= shifted;
      al_st_q       <= st;
    end
    if (cmd_i.dinit) begin
      nq_q   <= {1'b1, abs_sum_q[22:0], {(24 + CW){1'b0}}};
      rem_q  <= '0;
      dvs_q  <= (count_q == '0) ? CW'(1) : count_q;
      step_q <= '0;
      nsh_q  <= '0;
    end
    if (cmd_i.dstep) begin
      rem_q  <= dge ? CW'(dtmp - {1'b0, dvs_q}) : dtmp[CW-1:0];
      nq_q   <= {nq_q[QW-2:0], dge};
      step_q <= step_q + SW'(1);
    end
    if (cmd_i.nstep) begin
      nq_q  <= {nq_q[QW-2:0], 1'b0};
      nsh_q <= nsh_q + NW'(1);
    end
  end

  // ------------------------------------------------------------ quantise
  logic [31:0] res_q;
  logic        passed_q;

  logic        w_nan, w_inf, s_nan, s_inf;
  logic [7:0]  ewp;
  logic signed [9:0] kk;
  logic [23:0] mw, ms;
  logic [48:0] rhs;
  logic [71:0] lhs;
  logic        gt;
  logic [31:0] qres;

  always_comb begin
    w_nan = (w32[30:23] == 8'hff) && (w32[22:0] != '0);
    w_inf = (w32[30:23] == 8'hff) && (w32[22:0] == '0);
    s_nan = (scale_q[30:23] == 8'hff) && (scale_q[22:0] != '0);
    s_inf = (scale_q[30:23] == 8'hff) && (scale_q[22:0] == '0);
    ewp   = (w32[30:23] == 8'd0) ? 8'd1 : w32[30:23];
    kk    = $signed({2'd0, ewp}) - $signed({2'd0, scale_q[30:23]}) + 10'sd25;
    mw    = {w32[30:23] != 8'd0, w32[22:0]};
    ms    = {1'b1, scale_q[22:0]};
    // |w| > scale * (0.5 + 2^-25) decides a rounded quotient above one half
    rhs   = {1'b0, ms, 24'd0} + {25'd0, ms};
    lhs   = {48'd0, mw} << kk[5:0];
    if (kk >= 10'sd49) begin
      gt = 1'b1;
    end else if (kk <= 10'sd23) begin
      gt = 1'b0;
    end else begin
      gt = lhs > {23'd0, rhs};
    end
    if (w_nan) begin
      qres = w32 | 32'h0040_0000;
    end else if (s_nan) begin
      qres = scale_q | 32'h0040_0000;
    end else if (s_inf) begin
      qres = 32'hffc0_0000;
    end else if (w_inf || (gt && w32[30:0] != '0)) begin
      qres = {w32[31], scale_q[30:0]};
    end else begin
      qres = {w32[31], 31'd0};
    end
  end

  logic [31:0] final_bits;

  always_comb begin
    if (passed_q) begin
      final_bits = (fmt_i == taqnt_pkg::FmtBf16 || fmt_i == taqnt_pkg::FmtHalf) ?
                   {16'd0, raw_q[15:0]} : raw_q;
    end else begin
      case (fmt_i)
        taqnt_pkg::FmtBf16: final_bits = {16'd0, s2bf(res_q)};
        taqnt_pkg::FmtHalf: final_bits = {16'd0, s2h(res_q)};
        default:            final_bits = res_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.qcmp) begin
      res_q    <= qres;
      passed_q <= skip_q | (scale_q < taqnt_pkg::ScaleMin);
    end
    if (cmd_i.qout) begin
      quantized_bits_o <= final_bits;
      last_of_matrix_o <= last_q;
      passed_through_o <= passed_q;
    end
  end

  // -------------------------------------------------------- output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.qout) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_comb begin
    sts_o.op          = op_q;
    sts_o.last        = last_q;
    sts_o.cnt_full    = count_q >= CW'(MAX_ELEMENTS);
    sts_o.sum_special = (abs_sum_q[30:23] == 8'd0) || (abs_sum_q[30:23] == 8'hff);
    sts_o.div_last    = step_q == SW'(QW - 1);
    sts_o.norm_done   = nq_q[QW-1];
    sts_o.out_free    = !out_valid_o || !out_stall_i;
  end

endmodule

`default_nettype wire

FILE: hdl/ternary_absmean_weight_quantizer_top.sv
// Ternary absmean weight quantiser.
// Software streams one weight matrix twice over the input channel. Words with
// opcode 0 add |w| (in float32) to a running sum; the word marked last turns
// the sum into scale = sum / count. Words with opcode 1 each return one
// result word: +scale, -scale or signed zero in the element format, or the
// element unchanged with passed_through set when scale is below 1e-10.
// Element format (float32, bfloat16, float16) is set through the APB register
// at address 0 and must only change while the block is idle.
// Flow: one word at a time. The last accumulate word also starts a restoring
// divide of 48 + counter width steps (73 by default), then normalising shifts
// and a rounding step; a zero, subnormal or non-finite sum skips to rounding.
// A quantise word is compared into a result register and then loaded into the
// output register once that register is free.
// The output register frees the datapath: a new word is taken while a
// result waits. If the receiver stalls, the next quantise result waits in
// the datapath until the register is free, and input stall is held.
// Reset clears the sum, count, scale and format; quantising before any scale
// passes every element through.
`default_nettype none

module ternary_absmean_weight_quantizer_top #(
  parameter int unsigned MAX_ELEMENTS = taqnt_pkg::MaxElements
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input words
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         opcode_i,
  input  wire  [31:0] value_bits_i,
  input  wire         is_last_i,
  // result words
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] quantized_bits_o,
  output logic        last_of_matrix_o,
  output logic        passed_through_o,
  // register port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  taqnt_pkg::cmd_t    cmd;
  taqnt_pkg::status_t sts;

  // format register, the only one
  logic [1:0] fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 2'd0;
    end else if (psel && penable && pwrite) begin
      fmt_q <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == taqnt_pkg::AddrFormat) ? {30'd0, fmt_q} : 32'd0;

  taqnt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  taqnt_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .fmt_i            (fmt_q),
    .opcode_i         (opcode_i),
    .value_bits_i     (value_bits_i),
    .is_last_i        (is_last_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .quantized_bits_o (quantized_bits_o),
    .last_of_matrix_o (last_of_matrix_o),
    .passed_through_o (passed_through_o)
  );

endmodule

`default_nettype wire
